FILE: design/dbcl_pkg.sv
// Shared types and constants for the debounced two-button code lock.
`default_nettype none
package dbcl_pkg;

  localparam int MaxCodeBits = 12;
  localparam int CodeW       = 12;
  localparam int LenW        = 4;
  localparam int DebW        = 16;
  localparam int TickW       = 17;

  localparam logic [TickW-1:0] TickMax     = {TickW{1'b1}};
  localparam logic [LenW-1:0]  LenReset    = LenW'(4);
  localparam logic [DebW-1:0]  DebReset    = DebW'(50);
  localparam logic [LenW-1:0]  LenMax      = LenW'(MaxCodeBits);

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SECRET   = 2'd0,
    REG_LENGTH   = 2'd1,
    REG_DEBOUNCE = 2'd2,
    REG_NONE     = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [CodeW-1:0] secret_code;
    logic [LenW-1:0]  code_length;
    logic [DebW-1:0]  debounce_ticks;
  } cfg_t;

  typedef struct packed {
    logic restart;
    logic horn_pressed;
    logic mode_pressed;
  } in_t;

  typedef struct packed {
    logic            complete;
    logic            matched;
    logic [LenW-1:0] presses_left;
  } out_t;

  // zero reads as one, anything above the maximum clamps to it
  function automatic logic [LenW-1:0] eff_length(input logic [LenW-1:0] len);
    logic [LenW-1:0] r;
    r = len;
    if (len == '0) r = LenW'(1);
    if (len > LenMax) r = LenMax;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/dbcl_cfg_regs.sv
// Configuration register file for the code lock.
`default_nettype none
module dbcl_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_valid,
  output      logic          cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  output      dbcl_pkg::cfg_t cfg
);
  import dbcl_pkg::*;

  reg_index_t idx;

  assign cfg_ready = 1'b1;
  assign idx       = reg_index_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.secret_code    <= '0;
      cfg.code_length    <= LenReset;
      cfg.debounce_ticks <= DebReset;
    end else if (cfg_valid) begin
      case (idx)
        REG_SECRET:   cfg.secret_code    <= cfg_data[CodeW-1:0];
        REG_LENGTH:   cfg.code_length    <= cfg_data[LenW-1:0];
        REG_DEBOUNCE: cfg.debounce_ticks <= cfg_data[DebW-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/dbcl_lock_step.sv
// Lock state registers and the per-tick entry update.
`default_nettype none
module dbcl_lock_step (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire dbcl_pkg::cfg_t cfg,
  input  wire logic           advance,
  input  wire dbcl_pkg::in_t  word,
  output      dbcl_pkg::out_t res
);
  import dbcl_pkg::*;

  logic [CodeW-1:0] entered_bits, entered_bits_next;
  logic [LenW-1:0]  remaining_count, remaining_count_next;
  logic [TickW-1:0] ticks_since_press, ticks_since_press_next;

  logic [LenW-1:0]  len;
  logic [TickW-1:0] ticks_start;
  logic [TickW-1:0] elapsed;
  logic [LenW-1:0]  rem;
  logic [CodeW-1:0] bits_in;
  logic             press, take;

  always_comb begin
    len         = eff_length(cfg.code_length);
    ticks_start = {1'b0, cfg.debounce_ticks} + TickW'(1);
    elapsed     = (ticks_since_press == TickMax) ? TickMax : ticks_since_press + TickW'(1);
    press       = word.horn_pressed | word.mode_pressed;
    take        = !word.restart && press && (elapsed > {1'b0, cfg.debounce_ticks});
    rem         = (remaining_count != '0) ? remaining_count - LenW'(1) : '0;
    bits_in     = entered_bits;
    if (word.horn_pressed && rem < LenW'(CodeW))
      bits_in = entered_bits | (CodeW'(1) << rem);

    entered_bits_next      = entered_bits;
    remaining_count_next   = remaining_count;
    ticks_since_press_next = elapsed;
    res.complete           = 1'b0;
    res.matched            = 1'b0;

    if (word.restart) begin
      entered_bits_next      = '0;
      remaining_count_next   = len;
      ticks_since_press_next = ticks_start;
    end else if (take) begin
      entered_bits_next      = bits_in;
      remaining_count_next   = rem;
      ticks_since_press_next = '0;
      if (rem == '0) begin
        res.complete           = 1'b1;
        res.matched            = (cfg.secret_code == bits_in);
        entered_bits_next      = '0;
        remaining_count_next   = len;
        ticks_since_press_next = ticks_start;
      end
    end else if (press) begin
      // bounce inside the window only restarts the window
      ticks_since_press_next = '0;
    end
    res.presses_left = remaining_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entered_bits      <= '0;
      remaining_count   <= LenReset;
      ticks_since_press <= {1'b0, DebReset} + TickW'(1);
    end else if (advance) begin
      entered_bits      <= entered_bits_next;
      remaining_count   <= remaining_count_next;
      ticks_since_press <= ticks_since_press_next;
    end
  end

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    remaining_count <= LenMax)
    else $error("remaining count above max code length");

  a_restart_arms: assert property (@(posedge clk) disable iff (rst)
    advance && word.restart |=> ticks_since_press == {1'b0, cfg.debounce_ticks} + TickW'(1)
      && entered_bits == '0)
    else $error("restart did not rearm entry");

  a_complete_reload: assert property (@(posedge clk) disable iff (rst)
    advance && res.complete |=> remaining_count == eff_length(cfg.code_length)
      && entered_bits == '0)
    else $error("completion did not start a fresh entry");

endmodule
`default_nettype wire

FILE: design/debounced_two_button_code_lock_unit.sv
// Top level of the code lock: input register, entry update, result register.
//
//  channel | signals                              | dir  | word
//  in      | in_valid, in_ready, in_word          | sink | restart, horn, mode
//  out     | out_valid, out_ready, out_word       | src  | complete, matched, presses_left
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | sink | register write
//
// One word per cycle unless out stalls; path: input register, then result register.
// The state update sits between the two registers and fires as a word moves to the result.
// Stall on out holds the result; the input register still takes one more word.
// Reset clears valids, loads length 4, debounce 50 and arms the next press.
`default_nettype none
module debounced_two_button_code_lock_unit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output      logic           in_ready,
  input  wire dbcl_pkg::in_t  in_word,
  output      logic           out_valid,
  input  wire logic           out_ready,
  output      dbcl_pkg::out_t out_word,
  input  wire logic           cfg_valid,
  output      logic           cfg_ready,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [15:0]    cfg_data
);
  import dbcl_pkg::*;

  cfg_t cfg;
  in_t  hold_word;
  logic hold_valid;
  logic advance;
  out_t res;

  dbcl_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance  = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  dbcl_lock_step u_step (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .word    (hold_word),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_word <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= res;
    end
  end

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Testbench for the debounced two-button code lock: directed and random tick streams, scoreboarded.
module testbench;
  import dbcl_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int RandomTicks   = 1500;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_t        in_word   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_t       out_word;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  reg_index_t cfg_index = REG_NONE;
  logic [15:0] cfg_data = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  debounced_two_button_code_lock_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // lock model: registers and entry state
  logic [CodeW-1:0] secret_q;
  logic [LenW-1:0]  len_q;
  logic [DebW-1:0]  deb_q;
  logic [CodeW-1:0] code_acc;
  logic [LenW-1:0]  left_q;
  logic [TickW-1:0] since_q;

  out_t lock_results[$];
  out_t want;
  int   errors      = 0;
  int   ticks_sent  = 0;
  int   ready_hold  = 0;
  int   dead_cycles = 0;
  bit   idle_en     = 1'b1;

  function automatic logic [LenW-1:0] used_length();
    if (len_q == '0) return LenW'(1);
    if (len_q > LenW'(MaxCodeBits)) return LenW'(MaxCodeBits);
    return len_q;
  endfunction

  // fresh entry: next press is accepted right away
  function automatic void start_entry();
    left_q   = used_length();
    code_acc = '0;
    since_q  = TickW'(deb_q) + 1'b1;
  endfunction

  function automatic void lock_reset();
    secret_q = '0;
    len_q    = LenReset;
    deb_q    = DebReset;
    start_entry();
  endfunction

  function automatic out_t lock_tick(in_t w);
    out_t             r;
    logic [TickW-1:0] elapsed;
    logic [LenW-1:0]  rem;
    logic             press;
    r     = '0;
    press = w.horn_pressed | w.mode_pressed;
    if (w.restart) begin
      start_entry();
    end else begin
      elapsed = since_q;
      if (elapsed != TickMax) elapsed = elapsed + 1'b1;
      if (press && elapsed > TickW'(deb_q)) begin
        rem     = (left_q != '0) ? left_q - 1'b1 : '0;
        since_q = '0;
        if (w.horn_pressed && rem < MaxCodeBits) code_acc[rem] = 1'b1;
        left_q = rem;
        if (rem == '0) begin
          r.complete = 1'b1;
          r.matched  = (secret_q == code_acc);
          start_entry();
        end
      end else if (press) begin
        since_q = '0;  // bounce inside the window restarts it
      end else begin
        since_q = elapsed;
      end
    end
    r.presses_left = left_q;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic send_tick(bit rs, bit horn, bit mode);
    in_t w;
    w.restart      = rs;
    w.horn_pressed = horn;
    w.mode_pressed = mode;
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    lock_results.push_back(lock_tick(w));
    ticks_sent++;
  endtask

  task automatic idle_ticks(int n);
    repeat (n) send_tick(1'b0, 1'b0, 1'b0);
  endtask

  // wait until every result is back and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (lock_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SECRET:   secret_q = data[CodeW-1:0];
      REG_LENGTH:   len_q    = data[LenW-1:0];
      REG_DEBOUNCE: deb_q    = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // upper data bits are junk on purpose; a restart makes the length take effect
  task automatic set_lock(logic [CodeW-1:0] s, logic [LenW-1:0] l, logic [DebW-1:0] d);
    settle();
    write_reg(REG_SECRET, {4'($urandom), s});
    write_reg(REG_LENGTH, {12'($urandom), l});
    write_reg(REG_DEBOUNCE, d);
    send_tick(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // presses for bits n-1..0 of pat, with held-button bounce and quiet gaps
  task automatic enter_code(logic [CodeW-1:0] pat, int n);
    bit horn;
    bit mode;
    int gap;
    for (int i = n - 1; i >= 0; i--) begin
      horn = pat[i];
      mode = !pat[i] || ($urandom_range(0, 3) == 0);
      send_tick(1'b0, horn, mode);
      repeat ($urandom_range(0, 2)) send_tick(1'b0, horn, mode);
      gap = deb_q + $urandom_range(0, 2);
      if ($urandom_range(0, 9) == 0) gap = $urandom_range(0, deb_q);
      idle_ticks(gap);
    end
  endtask

  task automatic test_reset_state();
    send_tick(1'b0, 1'b1, 1'b0);  // armed after reset
    send_tick(1'b0, 1'b0, 1'b1);  // inside the window
    idle_ticks(3);
    send_tick(1'b1, 1'b1, 1'b1);  // buttons ignored on restart
    send_tick(1'b0, 1'b0, 1'b1);
  endtask

  task automatic test_directed_codes();
    set_lock(12'b1011, 4'd4, 16'd0);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b0, 1'b1, 1'b1);  // horn wins
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    // new length only applies at the next start of entry
    settle();
    write_reg(REG_LENGTH, 16'd2);
    write_reg(REG_NONE, 16'hFFFF);
    repeat (6) send_tick(1'b0, 1'b1, 1'b0);
    // secret bits above the length can never match
    set_lock(12'hFFF, 4'd4, 16'd0);
    repeat (4) send_tick(1'b0, 1'b1, 1'b0);
    // zero length acts as one
    set_lock(12'h000, 4'd0, 16'd0);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b0, 1'b1, 1'b0);
    // length above the maximum clamps
    set_lock(12'hFFF, 4'd15, 16'd1);
    enter_code(12'hFFF, MaxCodeBits);
  endtask

  // widest window: the press right after a restart is taken, later ones stay inside the window
  task automatic test_long_window();
    set_lock(12'h002, 4'd2, 16'hFFFF);
    send_tick(1'b0, 1'b1, 1'b0);
    idle_ticks(40);
    send_tick(1'b0, 1'b0, 1'b1);
    idle_ticks(3);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
  endtask

  task automatic test_random_entry();
    int               base;
    int               pick;
    int               n;
    logic [CodeW-1:0] s;
    logic [LenW-1:0]  l;
    logic [DebW-1:0]  d;
    base = ticks_sent;
    while (ticks_sent - base < RandomTicks) begin
      if (ticks_sent - base > RandomTicks * 4 / 5) idle_en = 1'b0;
      else idle_en = ($urandom_range(0, 3) != 0);
      s = 12'($urandom);
      l = 4'($urandom_range(1, 6));
      d = 16'($urandom_range(0, 4));
      case ($urandom_range(0, 9))
        0: s = '0;
        1: s = '1;
        2: l = 4'($urandom_range(12, 15));
        3: l = '0;
        4: begin
          d = 16'($urandom_range(40, 60));
          l = 4'($urandom_range(1, 2));
        end
        default: ;
      endcase
      set_lock(s, l, d);
      repeat ($urandom_range(3, 8)) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          enter_code(($urandom_range(0, 1) != 0) ? secret_q : 12'($urandom), used_length());
        end else if (pick == 7) begin
          repeat ($urandom_range(5, 15))
            send_tick($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end else if (pick == 8) begin
          n = used_length();
          if (n > 1) enter_code(12'($urandom), $urandom_range(1, n - 1));
          send_tick(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          idle_ticks($urandom_range(0, deb_q + 3));
        end
      end
    end
  endtask

  // result side: compare against the oldest expected word, stall in bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (lock_results.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = lock_results.pop_front();
          if (out_word.complete !== want.complete)
            report_mismatch($sformatf("complete %b, expected %b",
                                      out_word.complete, want.complete));
          if (out_word.matched !== want.matched)
            report_mismatch($sformatf("matched %b, expected %b",
                                      out_word.matched, want.matched));
          if (out_word.presses_left !== want.presses_left)
            report_mismatch($sformatf("presses_left %0d, expected %0d",
                                      out_word.presses_left, want.presses_left));
        end
      end
      if (ready_hold > 0) begin
        ready_hold--;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        ready_hold = $urandom_range(1, 18) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      dead_cycles <= 0;
    else
      dead_cycles <= dead_cycles + 1;
    if (dead_cycles >= WatchdogLimit) begin
      $display("watchdog: no handshake for %0d cycles", WatchdogLimit);
      $display("FAIL debounced_two_button_code_lock_unit");
      $finish;
    end
  end

  initial begin
    lock_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_directed_codes();
    test_long_window();
    test_random_entry();
    settle();
    repeat (6) @(posedge clk);
    if (errors == 0)
      $display("PASS debounced_two_button_code_lock_unit");
    else
      $display("FAIL debounced_two_button_code_lock_unit");
    $finish;
  end

endmodule

FILE: sim.f
design/dbcl_pkg.sv
design/dbcl_cfg_regs.sv
design/dbcl_lock_step.sv
design/debounced_two_button_code_lock_unit.sv
tb/testbench.sv
